### hdl/hftd_pkg.sv
`default_nettype none
package hftd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned RAW_W  = 20;
	localparam int unsigned HUM_W  = 14;
	localparam int unsigned TMP_W  = 15;
	localparam int unsigned IDX_W  = 3;

	// Product widths for the fixed-point conversions.
	localparam int unsigned HUM_PROD_W = RAW_W + HUM_W;
	localparam int unsigned TMP_PROD_W = RAW_W + TMP_W;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

	localparam logic [HUM_W-1:0] HUM_SCALE  = 14'd10000;
	localparam logic [TMP_W-1:0] TMP_SCALE  = 15'd20000;
	localparam logic [TMP_W-1:0] TMP_OFFSET = 15'd5000;

	localparam logic [HUM_W-1:0]        HUM_MAX = 14'd9999;
	localparam logic signed [TMP_W-1:0] TMP_MIN = -15'sd5000;
	localparam logic signed [TMP_W-1:0] TMP_MAX = 15'sd14999;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// Frame position: idle, then the index of the next expected byte.
	localparam logic [IDX_W-1:0] IDX_IDLE  = 3'd0;
	localparam logic [IDX_W-1:0] IDX_FIRST = 3'd1;
	localparam logic [IDX_W-1:0] IDX_LAST  = 3'd5;
	localparam logic [IDX_W-1:0] IDX_CRC   = 3'd6;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BUSY    = 2'd1,
		ST_CRC_ERR = 2'd2
	} status_t;

	typedef struct packed {
		status_t          status;
		logic [RAW_W-1:0] hum_raw;
		logic [RAW_W-1:0] tmp_raw;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// One byte of CRC-8, MSB first, no reflection.
	function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		v = crc ^ b;
		for (int k = 0; k < BYTE_W; k++) begin
			if (v[BYTE_W-1]) begin
				v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[BYTE_W-2:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage
`default_nettype wire

### hdl/hftd_in_if.sv
`default_nettype none
interface hftd_in_if;
	import hftd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);

endinterface
`default_nettype wire

### hdl/hftd_out_if.sv
`default_nettype none
interface hftd_out_if;
	import hftd_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic [RAW_W-1:0]         humidity_raw;
	logic [RAW_W-1:0]         temperature_raw;
	logic [HUM_W-1:0]         humidity_centi_pct;
	logic signed [TMP_W-1:0]  temperature_centi_deg;

	modport source (output valid, output status, output humidity_raw, output temperature_raw,
		output humidity_centi_pct, output temperature_centi_deg, input ready);
	modport sink (input valid, input status, input humidity_raw, input temperature_raw,
		input humidity_centi_pct, input temperature_centi_deg, output ready);

endinterface
`default_nettype wire

### hdl/hftd_front.sv
`default_nettype none
module hftd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	hftd_in_if.sink             rx,
	input  hftd_pkg::q_stat_t   qs,
	output logic                push,
	output hftd_pkg::frame_rec_t push_rec
);
	import hftd_pkg::*;

	logic [IDX_W-1:0]    idx_q;
	logic [BYTE_W-1:0]   crc_q;
	logic                busy_q;
	logic [5*BYTE_W-1:0] payload_q;

	logic              acc;
	logic              in_body;
	logic [BYTE_W-1:0] crc_next;

	assign rx.ready = !qs.full;
	assign acc      = rx.valid && rx.ready;
	assign in_body  = (idx_q >= IDX_FIRST) && (idx_q <= IDX_LAST);
	assign crc_next = crc8_feed(rx.frame_start ? CRC_INIT : crc_q, rx.rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= IDX_IDLE;
			crc_q  <= CRC_INIT;
			busy_q <= 1'b0;
		end else if (acc) begin
			if (rx.frame_start) begin
				crc_q  <= crc_next;
				busy_q <= rx.rx_byte[BYTE_W-1];
				idx_q  <= IDX_FIRST;
			end else if (in_body) begin
				crc_q <= crc_next;
				idx_q <= idx_q + 1'b1;
			end else begin
				idx_q <= IDX_IDLE;
			end
		end
	end

	// Bytes 1..5 shift in, so byte 1 ends up most significant.
	always_ff @(posedge clk) begin
		if (acc && !rx.frame_start && in_body) begin
			payload_q <= {payload_q[4*BYTE_W-1:0], rx.rx_byte};
		end
	end

	assign push = acc && !rx.frame_start && (idx_q == IDX_CRC);

	always_comb begin
		if (busy_q) begin
			push_rec.status = ST_BUSY;
		end else if (crc_q != rx.rx_byte) begin
			push_rec.status = ST_CRC_ERR;
		end else begin
			push_rec.status = ST_OK;
		end
		push_rec.hum_raw = payload_q[2*RAW_W-1:RAW_W];
		push_rec.tmp_raw = payload_q[RAW_W-1:0];
	end

endmodule
`default_nettype wire

### hdl/hftd_queue.sv
`default_nettype none
module hftd_queue #(
	parameter int unsigned DEPTH = hftd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  hftd_pkg::frame_rec_t push_rec,
	input  wire                  pop,
	output hftd_pkg::frame_rec_t head,
	output hftd_pkg::q_stat_t    qs
);
	import hftd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	frame_rec_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head     = mem_q[rd_ptr_q];
	assign qs.full  = (cnt_q == CNT_FULL);
	assign qs.empty = (cnt_q == '0);

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL) else $error("queue count exceeds depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop from empty queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> cnt_q != CNT_FULL) else $error("push into full queue");
`endif

endmodule
`default_nettype wire

### hdl/hftd_back.sv
`default_nettype none
module hftd_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  hftd_pkg::frame_rec_t head,
	input  hftd_pkg::q_stat_t    qs,
	output logic                 pop,
	hftd_out_if.source           res
);
	import hftd_pkg::*;

	logic                  v_s1;
	status_t               status_s1;
	logic [RAW_W-1:0]      hraw_s1;
	logic [RAW_W-1:0]      traw_s1;
	logic [HUM_PROD_W-1:0] hprod_s1;
	logic [TMP_PROD_W-1:0] tprod_s1;

	logic v_s2;
	logic adv1;
	logic adv2;

	assign adv2 = !v_s2 || res.ready;
	assign adv1 = !v_s1 || adv2;
	assign pop  = !qs.empty && adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= !qs.empty;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 1: scale the raw readings.
	always_ff @(posedge clk) begin
		if (pop) begin
			status_s1 <= head.status;
			hraw_s1   <= head.hum_raw;
			traw_s1   <= head.tmp_raw;
			hprod_s1  <= HUM_PROD_W'(head.hum_raw) * HUM_PROD_W'(HUM_SCALE);
			tprod_s1  <= TMP_PROD_W'(head.tmp_raw) * TMP_PROD_W'(TMP_SCALE);
		end
	end

	// Stage 2: drop the fraction, apply the temperature offset.
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			res.status                <= status_s1;
			res.humidity_raw          <= hraw_s1;
			res.temperature_raw       <= traw_s1;
			res.humidity_centi_pct    <= hprod_s1[HUM_PROD_W-1:RAW_W];
			res.temperature_centi_deg <= $signed(tprod_s1[TMP_PROD_W-1:RAW_W] - TMP_OFFSET);
		end
	end

	assign res.valid = v_s2;

`ifndef SYNTHESIS
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.status == ST_OK || res.status == ST_BUSY ||
			res.status == ST_CRC_ERR)) else $error("undefined status code");
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.humidity_centi_pct <= HUM_MAX) else $error("humidity out of range");
	a_tmp_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.temperature_centi_deg >= TMP_MIN &&
			res.temperature_centi_deg <= TMP_MAX)) else $error("temperature out of range");
`endif

endmodule
`default_nettype wire

### hdl/humidity_temp_frame_decoder_unit.sv
`default_nettype none
// Channel  Dir  Words                   Payload
// rx       in   one frame byte          rx_byte[7:0], frame_start
// res      out  one decoded frame       status[1:0], humidity_raw[19:0],
//                                       temperature_raw[19:0], humidity_centi_pct[13:0],
//                                       temperature_centi_deg[14:0] (signed)
//
// Bytes are taken one per cycle unless the queue is full; each CRC-8 step is combinational.
// A frame's result passes through the queue and the stage-1 and stage-2 registers.
// Reset (arst_n low) drops any open frame and empties the queue and the result stages.
// rx stalls only when the frame queue is full, which happens when res is held back.
// res may stall at will; results wait in the queue and the two output stages.
module humidity_temp_frame_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = hftd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	hftd_in_if.sink    rx,
	hftd_out_if.source res
);
	import hftd_pkg::*;

	// The front tracks the frame position, the running CRC and the payload bytes. On the
	// CRC byte it classifies the frame (busy first, then CRC mismatch) and pushes a record.
	logic       push;
	frame_rec_t push_rec;
	frame_rec_t head;
	q_stat_t    qs;
	logic       pop;

	hftd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.qs       (qs),
		.push     (push),
		.push_rec (push_rec)
	);

	// The queue decouples the byte stream from the result side, so a stalled result
	// does not hold the front until the queue fills.
	hftd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.qs       (qs)
	);

	// The back scales the raw readings in one stage and forms the final values in the
	// output register of the next.
	hftd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qs     (qs),
		.pop    (pop),
		.res    (res)
	);

endmodule
`default_nettype wire
